// ===== rtl/core/ifmt_pkg.sv =====
// Shared types, codes and constants for the integer to ASCII formatter.
// Used by ifmt_ctrl, ifmt_dp and integer_to_ascii_formatter_unit; no dependencies.
package ifmt_pkg;

  localparam int DIGIT_DEPTH = 20;
  localparam int IDX_W       = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);

  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHR = 35;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_LHEX = 3'd2;
  localparam logic [2:0] MODE_UHEX = 3'd3;
  localparam logic [2:0] MODE_PTR  = 3'd4;
  localparam logic [2:0] MODE_CHAR = 3'd5;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_UA    = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_SPLIT,
    ST_PRE0,
    ST_PRE1,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_MINUS,
    EMIT_ZERO,
    EMIT_X,
    EMIT_DIGIT,
    EMIT_CHAR
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      split;
    emit_sel_t emit;
  } cmd_t;

  typedef struct packed {
    logic mode_ok;
    logic mode_char;
    logic split_last;
    logic neg;
    logic ptr;
    logic cnt_one;
    logic out_ready;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else if (upper) begin
      c = CHAR_UA + {4'b0000, d} - 8'd10;
    end else begin
      c = CHAR_LA + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter.
// Depends on ifmt_pkg, ifmt_ctrl and ifmt_dp.
//
// One input word (mode and 64-bit value) is formatted as printf would for
// %d, %u, %x, %X, %p or %c, and the characters leave most significant first,
// one output word per character, with out_last on the final one. Modes 6 and
// 7 are accepted and produce nothing. Only one conversion is in flight: the
// input is stalled from acceptance until the last character has been loaded
// into the output register. After acceptance the value is split one digit
// per cycle (a reciprocal multiply for decimal, a nibble shift for hex), then
// one character is loaded per cycle while the output is not stalled.
module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last
);

  ifmt_pkg::cmd_t cmd;
  ifmt_pkg::sts_t sts;

  ifmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ifmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

// ===== rtl/core/ifmt_ctrl.sv =====
// Sequencing state machine of the integer to ASCII formatter.
// Depends on ifmt_pkg; drives commands to ifmt_dp and reads its status.
module ifmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ifmt_pkg::sts_t sts,
  output ifmt_pkg::cmd_t cmd
);

  ifmt_pkg::state_t state_r;
  ifmt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ifmt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.split = 1'b0;
    cmd.emit  = ifmt_pkg::EMIT_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      ifmt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.mode_char) begin
            state_nxt = ifmt_pkg::ST_CHAR;
          end else if (sts.mode_ok) begin
            state_nxt = ifmt_pkg::ST_SPLIT;
          end
        end
      end
      ifmt_pkg::ST_CHAR: begin
        if (sts.out_ready) begin
          cmd.emit  = ifmt_pkg::EMIT_CHAR;
          state_nxt = ifmt_pkg::ST_IDLE;
        end
      end
      ifmt_pkg::ST_SPLIT: begin
        cmd.split = 1'b1;
        if (sts.split_last) begin
          state_nxt = (sts.neg || sts.ptr) ? ifmt_pkg::ST_PRE0 : ifmt_pkg::ST_EMIT;
        end
      end
      ifmt_pkg::ST_PRE0: begin
        if (sts.out_ready) begin
          cmd.emit  = sts.neg ? ifmt_pkg::EMIT_MINUS : ifmt_pkg::EMIT_ZERO;
          state_nxt = sts.ptr ? ifmt_pkg::ST_PRE1 : ifmt_pkg::ST_EMIT;
        end
      end
      ifmt_pkg::ST_PRE1: begin
        if (sts.out_ready) begin
          cmd.emit  = ifmt_pkg::EMIT_X;
          state_nxt = ifmt_pkg::ST_EMIT;
        end
      end
      ifmt_pkg::ST_EMIT: begin
        if (sts.out_ready) begin
          cmd.emit = ifmt_pkg::EMIT_DIGIT;
          if (sts.cnt_one) begin
            state_nxt = ifmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ifmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ifmt_dp.sv =====
// Datapath of the integer to ASCII formatter: work value, digit split, digit
// registers and the output word register. Depends on ifmt_pkg; driven by ifmt_ctrl.
module ifmt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [2:0]     in_mode,
  input  logic [63:0]    in_value,
  input  ifmt_pkg::cmd_t cmd,
  output ifmt_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_char,
  output logic           out_last
);

  logic [63:0]                work_r;
  logic [63:0]                work_nxt;
  logic [3:0]                 digit_r [ifmt_pkg::DIGIT_DEPTH];
  logic [ifmt_pkg::CNT_W-1:0] cnt_r;
  logic [ifmt_pkg::CNT_W-1:0] cnt_nxt;
  logic [ifmt_pkg::CNT_W-1:0] rd_idx;
  logic                       dec_r;
  logic                       upper_r;
  logic                       neg_r;
  logic                       ptr_r;
  logic [7:0]                 byte_r;
  logic                       out_valid_r;
  logic [7:0]                 out_char_r;
  logic                       out_last_r;

  logic [31:0] load_low;
  logic        load_neg;
  logic [63:0] prod;
  logic [28:0] quot;
  logic [3:0]  rem;
  logic [63:0] step_next;
  logic [3:0]  step_digit;
  logic        out_ready;
  logic [7:0]  emit_char;

  assign load_low = in_value[31:0];
  assign load_neg = (in_mode == ifmt_pkg::MODE_SDEC) && load_low[31];

  assign prod = {32'b0, work_r[31:0]} * {32'b0, ifmt_pkg::RECIP10};
  assign quot = prod[63:ifmt_pkg::RECIP_SHR];
  assign rem  = work_r[3:0] - 4'({quot[0], 3'b000} + {quot[2:0], 1'b0});

  always_comb begin
    if (dec_r) begin
      step_next  = {35'b0, quot};
      step_digit = rem;
    end else begin
      step_next  = {4'b0000, work_r[63:4]};
      step_digit = work_r[3:0];
    end
  end

  assign rd_idx    = cnt_r - ifmt_pkg::CNT_W'(1);
  assign out_ready = !out_valid_r || !out_stall;

  assign sts.mode_ok    = (in_mode <= ifmt_pkg::MODE_CHAR);
  assign sts.mode_char  = (in_mode == ifmt_pkg::MODE_CHAR);
  assign sts.split_last = (step_next == 64'b0) ||
                          (cnt_r == ifmt_pkg::CNT_W'(ifmt_pkg::DIGIT_DEPTH - 1));
  assign sts.neg        = neg_r;
  assign sts.ptr        = ptr_r;
  assign sts.cnt_one    = (cnt_r == ifmt_pkg::CNT_W'(1));
  assign sts.out_ready  = out_ready;

  always_comb begin
    case (cmd.emit)
      ifmt_pkg::EMIT_MINUS: emit_char = ifmt_pkg::CHAR_MINUS;
      ifmt_pkg::EMIT_ZERO:  emit_char = ifmt_pkg::CHAR_ZERO;
      ifmt_pkg::EMIT_X:     emit_char = ifmt_pkg::CHAR_X;
      ifmt_pkg::EMIT_DIGIT: emit_char = ifmt_pkg::digit_char(digit_r[rd_idx[ifmt_pkg::IDX_W-1:0]],
                                                             upper_r);
      ifmt_pkg::EMIT_CHAR:  emit_char = byte_r;
      default:              emit_char = 8'h00;
    endcase
  end

  always_comb begin
    work_nxt = work_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      if (in_mode == ifmt_pkg::MODE_PTR) begin
        work_nxt = in_value;
      end else begin
        work_nxt = {32'b0, load_neg ? (~load_low + 32'd1) : load_low};
      end
      cnt_nxt = '0;
    end else if (cmd.split) begin
      work_nxt = step_next;
      cnt_nxt  = cnt_r + ifmt_pkg::CNT_W'(1);
    end else if (cmd.emit == ifmt_pkg::EMIT_DIGIT) begin
      cnt_nxt = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.emit != ifmt_pkg::EMIT_NONE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (cmd.load) begin
      dec_r   <= (in_mode == ifmt_pkg::MODE_SDEC) || (in_mode == ifmt_pkg::MODE_UDEC);
      upper_r <= (in_mode == ifmt_pkg::MODE_UHEX);
      neg_r   <= load_neg;
      ptr_r   <= (in_mode == ifmt_pkg::MODE_PTR);
      byte_r  <= in_value[7:0];
    end
    if (cmd.split) begin
      digit_r[cnt_r[ifmt_pkg::IDX_W-1:0]] <= step_digit;
    end
    if (cmd.emit != ifmt_pkg::EMIT_NONE) begin
      out_char_r <= emit_char;
      out_last_r <= (cmd.emit == ifmt_pkg::EMIT_CHAR) ||
                    ((cmd.emit == ifmt_pkg::EMIT_DIGIT) && (cnt_r == ifmt_pkg::CNT_W'(1)));
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != ifmt_pkg::EMIT_NONE) |-> out_ready)
    else $error("word loaded while output register is occupied and stalled");

  a_digit_present: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit == ifmt_pkg::EMIT_DIGIT) |-> (cnt_r != '0))
    else $error("digit emitted with no digits stored");

  a_split_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split |-> (cnt_r < ifmt_pkg::CNT_W'(ifmt_pkg::DIGIT_DEPTH)))
    else $error("digit split beyond the digit registers");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split |=> (cnt_r == $past(cnt_r) + ifmt_pkg::CNT_W'(1)))
    else $error("digit count did not advance on a split step");

endmodule

// ===== test/ifmt_text_checker.sv =====
// Checker for the integer to ASCII formatter: watches both channels, predicts
// the characters of every accepted request word and compares each output word.
// Depends on ifmt_pkg for the mode codes, the character codes and DIGIT_DEPTH.
module ifmt_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char,
  input  logic        out_last,
  output int          mismatches,
  output int          chars_pending,
  output int          words_taken,
  output int          chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } glyph_t;

  glyph_t text_due[$];
  int     fault_tally = 0;
  int     word_tally  = 0;
  int     char_tally  = 0;

  function automatic void add_glyph(input logic [7:0] ch, input logic last);
    glyph_t g;
    g.ch   = ch;
    g.last = last;
    text_due.push_back(g);
  endfunction

  function automatic void predict_text(input logic [2:0] mode, input logic [63:0] value);
    logic [63:0] rest;
    logic [63:0] radix;
    logic [3:0]  digits [ifmt_pkg::DIGIT_DEPTH];
    int          count;
    string       numerals;
    if (mode == ifmt_pkg::MODE_CHAR) begin
      add_glyph(value[7:0], 1'b1);
      return;
    end
    if (mode > ifmt_pkg::MODE_PTR) begin
      return;
    end
    radix    = 64'd16;
    numerals = "0123456789abcdef";
    rest     = {32'd0, value[31:0]};
    case (mode)
      ifmt_pkg::MODE_SDEC: begin
        radix = 64'd10;
        if (value[31]) begin
          add_glyph(ifmt_pkg::CHAR_MINUS, 1'b0);
          rest = {32'd0, 32'(-value[31:0])};
        end
      end
      ifmt_pkg::MODE_UDEC: begin
        radix = 64'd10;
      end
      ifmt_pkg::MODE_UHEX: begin
        numerals = "0123456789ABCDEF";
      end
      ifmt_pkg::MODE_PTR: begin
        add_glyph(ifmt_pkg::CHAR_ZERO, 1'b0);
        add_glyph(ifmt_pkg::CHAR_X, 1'b0);
        rest = value;
      end
      default: begin
      end
    endcase
    count = 0;
    do begin
      digits[count] = 4'(rest % radix);
      rest = rest / radix;
      count++;
    end while (rest != 64'd0 && count < ifmt_pkg::DIGIT_DEPTH);
    for (int i = count - 1; i >= 0; i--) begin
      add_glyph(numerals[int'(digits[i])], i == 0);
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (rst_n && out_valid && !out_stall) begin
      char_tally++;
      if (text_due.size() == 0) begin
        fault_tally++;
        $display("%0t: unexpected output word: char %h last %b", $time, out_char, out_last);
      end else begin
        want = text_due.pop_front();
        if (out_char !== want.ch) begin
          fault_tally++;
          $display("%0t: char mismatch: expected %h, actual %h", $time, want.ch, out_char);
        end
        if (out_last !== want.last) begin
          fault_tally++;
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, out_last);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      word_tally++;
      predict_text(in_mode, in_value);
    end
    mismatches    <= fault_tally;
    chars_pending <= text_due.size();
    words_taken   <= word_tally;
    chars_checked <= char_tally;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the formatter testbench: clock, reset and stimulus, with the verdict.
// Depends on ifmt_pkg, integer_to_ascii_formatter_unit and ifmt_text_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE6  = 3'd6;
  localparam logic [2:0] MODE_SPARE7  = 3'd7;
  localparam int         RANDOM_WORDS = 420;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char;
  logic        out_last;
  bit          calm;
  int          cycle_count;
  int          mismatches;
  int          chars_pending;
  int          words_taken;
  int          chars_checked;

  integer_to_ascii_formatter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_value (in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .out_last (out_last)
  );

  ifmt_text_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .chars_pending(chars_pending),
    .words_taken  (words_taken),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  task automatic send_word(input logic [2:0] mode, input logic [63:0] value);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [31:0] p;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      1: begin
        v[31:0] = $urandom_range(0, 20);
      end
      2: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        v[31:0] = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      3: begin
        v = 64'd1 << $urandom_range(0, 63);
      end
      4: begin
        if ($urandom_range(0, 3) == 0) begin
          v = '1;
        end else begin
          v[31:0] = -32'($urandom_range(1, 20));
        end
      end
      5: begin
        v = v >> $urandom_range(0, 63);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [2:0] mode;
    int         sent;
    in_valid  <= 1'b0;
    in_mode   <= ifmt_pkg::MODE_SDEC;
    in_value  <= 64'd0;
    rst_n     <= 1'b0;
    calm      <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(ifmt_pkg::MODE_SDEC, 64'd0);
    send_word(ifmt_pkg::MODE_SDEC, 64'h0000_0000_8000_0000);
    send_word(ifmt_pkg::MODE_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_word(ifmt_pkg::MODE_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_word(ifmt_pkg::MODE_SDEC, 64'hFFFF_FFFF_0000_007B);
    send_word(ifmt_pkg::MODE_UDEC, 64'd0);
    send_word(ifmt_pkg::MODE_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_word(ifmt_pkg::MODE_UDEC, 64'hA5A5_A5A5_3B9A_CA00);
    send_word(ifmt_pkg::MODE_LHEX, 64'd0);
    send_word(ifmt_pkg::MODE_LHEX, 64'hFFFF_FFFF_DEAD_BEEF);
    send_word(ifmt_pkg::MODE_LHEX, 64'h1234_5678_0000_000A);
    send_word(ifmt_pkg::MODE_UHEX, 64'h0000_0000_FFFF_FFFF);
    send_word(ifmt_pkg::MODE_UHEX, 64'h8000_0000_0000_0000);
    send_word(ifmt_pkg::MODE_UHEX, 64'h0000_0000_ABCD_EF01);
    send_word(ifmt_pkg::MODE_PTR, 64'd0);
    send_word(ifmt_pkg::MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(ifmt_pkg::MODE_PTR, 64'h8000_0000_0000_0000);
    send_word(ifmt_pkg::MODE_PTR, 64'h0000_0000_1234_5678);
    send_word(ifmt_pkg::MODE_CHAR, 64'd0);
    send_word(ifmt_pkg::MODE_CHAR, 64'h0000_0000_0000_00FF);
    send_word(ifmt_pkg::MODE_CHAR, 64'hFFFF_FFFF_FFFF_FF41);
    send_word(MODE_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(MODE_SPARE7, 64'h0000_0000_0000_0001);
    send_word(ifmt_pkg::MODE_SDEC, 64'h0000_0000_FFFF_FFF6);

    // The middle of the random part runs with no idling on either side.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      calm <= (sent >= 200 && sent < 290);
      if ($urandom_range(0, 15) == 0) begin
        mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
      end else begin
        mode = 3'($urandom_range(0, 5));
      end
      send_word(mode, random_value());
      if (mode <= ifmt_pkg::MODE_CHAR) begin
        sent++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (chars_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d request words over all six modes and the two spare codes,",
             words_taken);
    $display("with %0d output characters compared under random idling and stalls.",
             chars_checked);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ifmt_pkg.sv
rtl/core/ifmt_ctrl.sv
rtl/core/ifmt_dp.sv
rtl/core/integer_to_ascii_formatter_unit.sv
test/ifmt_text_checker.sv
test/testbench.sv
